// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define RMF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: invariant failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define RMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

// File: hw/rtl/rmf_pkg.sv
// Package with sizes and types shared by the running median filter.
package rmf_pkg;

  localparam int WINDOW_LEN   = 13;
  localparam int SAMPLE_WIDTH = 16;
  localparam int SLOT_W       = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W        = $clog2(WINDOW_LEN + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_word_t;
  typedef logic [SLOT_W-1:0]              slot_t;
  typedef logic [CNT_W-1:0]               count_t;

  // One sorted entry: a sample and the window slot it came from.
  typedef struct packed {
    sample_word_t value;
    slot_t        slot;
  } entry_t;

  // Passed from a cell to its right neighbor.
  typedef struct packed {
    logic   rm_seen;   // the retiring slot sits in this cell or to its left
    logic   a_le;      // the entry after removal is <= the new sample
    entry_t a_entry;   // the entry at this place after removal
  } fwd_link_t;

  // Passed from a cell to its left neighbor.
  typedef struct packed {
    logic   le;        // held, not retiring, and <= the new sample
    entry_t entry;
  } bwd_link_t;

endpackage

// File: hw/rtl/rmf_cell.sv
// One cell of the sorted row: holds an entry and updates it from its neighbors.
module rmf_cell (
  input  logic                clk,
  input  logic                en,
  input  logic                held,
  input  rmf_pkg::slot_t      retire_slot,
  input  rmf_pkg::entry_t     new_entry,
  input  rmf_pkg::fwd_link_t  from_left,
  input  rmf_pkg::bwd_link_t  from_right,
  output rmf_pkg::fwd_link_t  to_right,
  output rmf_pkg::bwd_link_t  to_left,
  output rmf_pkg::entry_t     entry
);

  rmf_pkg::entry_t entry_r;
  rmf_pkg::entry_t entry_nxt;
  logic            rm_here;
  logic            le_raw;

  assign rm_here = held && (entry_r.slot == retire_slot);
  assign le_raw  = held && !rm_here &&
                   ($signed(entry_r.value) <= $signed(new_entry.value));

  assign to_left.le    = le_raw;
  assign to_left.entry = entry_r;

  // Once the retiring entry lies at or left of this cell, the row closes up by one.
  assign to_right.rm_seen = from_left.rm_seen || rm_here;
  assign to_right.a_le    = to_right.rm_seen ? from_right.le : le_raw;
  assign to_right.a_entry = to_right.rm_seen ? from_right.entry : entry_r;

  // Keep the closed-up entry, take the new sample, or shift right to make room.
  always_comb begin
    priority if (to_right.a_le) begin
      entry_nxt = to_right.a_entry;
    end else if (from_left.a_le) begin
      entry_nxt = new_entry;
    end else begin
      entry_nxt = from_left.a_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

// File: hw/rtl/running_median_filter.sv
// Running median filter: a row of sorted cells fed one sample beat at a time.
// After a beat is accepted the cells update, then its median is registered into the output.
// Throughput: one beat per cycle while the input is not stalled; all cells update in parallel.
// The input stalls only while a finished median waits for a stalled output.
// Synchronous active-low reset empties the window and restarts at slot zero.
`include "assert_macros.svh"

module running_median_filter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rmf_pkg::sample_word_t in_sample_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rmf_pkg::sample_word_t out_median_out
);

  rmf_pkg::slot_t        write_slot_r, write_slot_nxt;
  rmf_pkg::count_t       fill_r, fill_nxt;
  logic                  pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rmf_pkg::sample_word_t median_r;

  logic             accept;
  logic             out_load;
  logic             full;
  rmf_pkg::entry_t  new_entry;
  rmf_pkg::slot_t   mid_idx;

  rmf_pkg::fwd_link_t fwd [rmf_pkg::WINDOW_LEN+1];
  rmf_pkg::bwd_link_t bwd [rmf_pkg::WINDOW_LEN+1];
  rmf_pkg::entry_t    cell_entry [rmf_pkg::WINDOW_LEN];

  assign out_load = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_r && !out_load;
  assign accept   = in_valid && !in_stall;
  assign full     = (fill_r == rmf_pkg::count_t'(rmf_pkg::WINDOW_LEN));

  assign new_entry.value = in_sample_in;
  assign new_entry.slot  = write_slot_r;

  // Ends of the row: nothing sits left of the first cell or right of the last.
  assign fwd[0].rm_seen = 1'b0;
  assign fwd[0].a_le    = 1'b1;
  assign fwd[0].a_entry = '0;
  assign bwd[rmf_pkg::WINDOW_LEN].le    = 1'b0;
  assign bwd[rmf_pkg::WINDOW_LEN].entry = '0;

  for (genvar i = 0; i < rmf_pkg::WINDOW_LEN; i++) begin : g_cell
    logic held;
    assign held = (rmf_pkg::count_t'(i) < fill_r);

    rmf_cell u_cell (
      .clk         (clk),
      .en          (accept),
      .held        (held),
      .retire_slot (write_slot_r),
      .new_entry   (new_entry),
      .from_left   (fwd[i]),
      .from_right  (bwd[i+1]),
      .to_right    (fwd[i+1]),
      .to_left     (bwd[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    write_slot_nxt = write_slot_r;
    fill_nxt       = fill_r;
    if (accept) begin
      write_slot_nxt = (write_slot_r == rmf_pkg::slot_t'(rmf_pkg::WINDOW_LEN - 1)) ?
                       '0 : write_slot_r + rmf_pkg::slot_t'(1);
      if (!full) begin
        fill_nxt = fill_r + rmf_pkg::count_t'(1);
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt = 1'b1;
    end else if (out_load) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // The median sits at sorted position fill/2 once the row has settled.
  assign mid_idx = rmf_pkg::slot_t'(fill_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      fill_r       <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      write_slot_r <= write_slot_nxt;
      fill_r       <= fill_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median_r <= cell_entry[mid_idx].value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_median_out = median_r;

  `RMF_ASSERT_ALWAYS(a_fill_bound, fill_r <= rmf_pkg::count_t'(rmf_pkg::WINDOW_LEN))
  `RMF_ASSERT_ALWAYS(a_slot_bound, write_slot_r < rmf_pkg::slot_t'(rmf_pkg::WINDOW_LEN))
  `RMF_ASSERT_IMPL(a_fill_slot, !full, rmf_pkg::count_t'(write_slot_r) == fill_r)
  `RMF_ASSERT_IMPL(a_retire_found, accept && full, fwd[rmf_pkg::WINDOW_LEN].rm_seen)

endmodule
